// ===== rtl/tms_pkg.sv =====
// Package for the terminal multiplexer status and scan core.
// Holds the line count, function codes, bus word bit positions and the transaction types.
// Used by every module in rtl/; has no dependencies of its own.
package tms_pkg;

    localparam int NUM_LINES = 32;
    localparam int LINE_W    = 5;
    localparam int WORD_W    = 36;
    localparam int CHAR_W    = 7;
    localparam int MASK_W    = 32;
    localparam int NUM_CHARS = 5;
    localparam int IDX_W     = 3;

    localparam logic [MASK_W-1:0] LINE_MASK =
        MASK_W'((64'd1 << NUM_LINES) - 64'd1);

    localparam logic [2:0] FUNC_CTRL_WR = 3'd0;
    localparam logic [2:0] FUNC_STAT_RD = 3'd1;
    localparam logic [2:0] FUNC_DATA_WR = 3'd2;
    localparam logic [2:0] FUNC_DATA_RD = 3'd3;
    localparam logic [2:0] FUNC_SCAN    = 3'd4;

    localparam int CW_REQ_BIT  = 3;
    localparam int CW_STOP_BIT = 7;
    localparam int CW_SEL_LSB  = 12;

    typedef struct packed {
        logic [2:0]        func;
        logic [WORD_W-1:0] bus_word;
        logic [CHAR_W-1:0] rx_char;
        logic [MASK_W-1:0] tx_ready_edge;
        logic [MASK_W-1:0] rx_pending;
        logic [MASK_W-1:0] line_connected;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic              tx_valid;
        logic [CHAR_W-1:0] tx_char;
        logic [LINE_W-1:0] sel_line;
        logic              rx_take;
        logic              irq_active;
        logic [2:0]        irq_level;
        logic              last;
    } result_t;

    typedef struct packed {
        logic              found;
        logic              is_tx;
        logic [LINE_W-1:0] line;
    } scan_hit_t;

endpackage

// ===== rtl/terminal_mux_status_and_scan_core.sv =====
// Top level of the terminal multiplexer status and scan core.
// A result transaction is registered in out_reg from the item held in hold_reg.
// Throughput: one result per cycle; a single-result item every cycle, a data write one per character.
// These need result_stall low; tms_core's sequencer paces data writes, at most five characters each.
// Reset (rst_n, asynchronous, active low) clears the status register, the scan pointer
// and both valid flags, so item_stall is low and the block accepts items once reset ends.
module terminal_mux_status_and_scan_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  tms_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_stall,
    output tms_pkg::result_t  result
);

    logic             hold_valid_reg;
    tms_pkg::item_t   hold_reg;
    logic             out_valid_reg;
    tms_pkg::result_t out_reg;
    tms_pkg::result_t core_res;
    logic             out_free;
    logic             fire;
    logic             finish;

    assign out_free   = !out_valid_reg || !result_stall;
    assign fire       = hold_valid_reg && out_free;
    assign finish     = fire && core_res.last;
    assign item_stall = hold_valid_reg && !finish;

    tms_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (hold_reg),
        .fire  (fire),
        .res   (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (!item_stall)
            begin
                hold_valid_reg <= item_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= fire;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            hold_reg <= item;
        end
        if (fire)
        begin
            out_reg <= core_res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== rtl/tms_scan.sv =====
// Round-robin line scanner: finds the first line after the scan pointer that needs service.
// Depends on tms_pkg for the line count and the scan_hit_t type.
module tms_scan
(
    input  logic [tms_pkg::LINE_W-1:0] ptr,
    input  logic [tms_pkg::MASK_W-1:0] tx_ready_edge,
    input  logic [tms_pkg::MASK_W-1:0] rx_pending,
    input  logic [tms_pkg::MASK_W-1:0] line_connected,
    output tms_pkg::scan_hit_t         hit
);

    logic [tms_pkg::MASK_W-1:0] req;
    logic [tms_pkg::NUM_LINES-1:0] rot;
    logic [tms_pkg::LINE_W:0] sum [tms_pkg::NUM_LINES];
    logic [tms_pkg::LINE_W-1:0] pos [tms_pkg::NUM_LINES];

    assign req = (tx_ready_edge | (rx_pending & line_connected)) & tms_pkg::LINE_MASK;

    always_comb
    begin
        for (int k = 0; k < tms_pkg::NUM_LINES; k++)
        begin
            sum[k] = {1'b0, ptr} + (tms_pkg::LINE_W+1)'(1) + (tms_pkg::LINE_W+1)'(k);
            if (sum[k] >= (tms_pkg::LINE_W+1)'(tms_pkg::NUM_LINES))
            begin
                sum[k] = sum[k] - (tms_pkg::LINE_W+1)'(tms_pkg::NUM_LINES);
            end
            pos[k] = sum[k][tms_pkg::LINE_W-1:0];
            rot[k] = req[pos[k]];
        end
    end

    always_comb
    begin
        hit.found = 1'b0;
        hit.line  = '0;
        for (int k = 0; k < tms_pkg::NUM_LINES; k++)
        begin
            if (!hit.found && rot[k])
            begin
                hit.found = 1'b1;
                hit.line  = pos[k];
            end
        end
        hit.is_tx = tx_ready_edge[hit.line];
    end

endmodule

// ===== rtl/tms_core.sv =====
// Status register, scan pointer and character sequencer of the terminal multiplexer.
// Builds one result per fired cycle from the held item; depends on tms_pkg and tms_scan.
module tms_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  tms_pkg::item_t    item,
    input  logic              fire,
    output tms_pkg::result_t  res
);

    logic [2:0]                 level_reg, level_next;
    logic [tms_pkg::LINE_W-1:0] sel_reg, sel_next;
    logic                       odone_reg, odone_next;
    logic                       idone_reg, idone_next;
    logic [tms_pkg::LINE_W-1:0] ptr_reg, ptr_next;
    logic [tms_pkg::IDX_W-1:0]  idx_reg, idx_next;

    logic [tms_pkg::CHAR_W-1:0] chars [tms_pkg::NUM_CHARS];
    logic [tms_pkg::CHAR_W-1:0] cur_char;
    logic                       end_of_chars;
    tms_pkg::scan_hit_t         scan_hit;

    tms_scan u_scan
    (
        .ptr            (ptr_reg),
        .tx_ready_edge  (item.tx_ready_edge),
        .rx_pending     (item.rx_pending),
        .line_connected (item.line_connected),
        .hit            (scan_hit)
    );

    always_comb
    begin
        for (int i = 0; i < tms_pkg::NUM_CHARS; i++)
        begin
            chars[i] = item.bus_word[tms_pkg::WORD_W-1-tms_pkg::CHAR_W*i -: tms_pkg::CHAR_W];
        end
        case (idx_reg)
            3'd0:
            begin
                cur_char     = chars[0];
                end_of_chars = (chars[1] == '0);
            end
            3'd1:
            begin
                cur_char     = chars[1];
                end_of_chars = (chars[2] == '0);
            end
            3'd2:
            begin
                cur_char     = chars[2];
                end_of_chars = (chars[3] == '0);
            end
            3'd3:
            begin
                cur_char     = chars[3];
                end_of_chars = (chars[4] == '0);
            end
            default:
            begin
                cur_char     = chars[4];
                end_of_chars = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        level_next    = level_reg;
        sel_next      = sel_reg;
        odone_next    = odone_reg;
        idone_next    = idone_reg;
        ptr_next      = ptr_reg;
        res.read_data = '0;
        res.tx_valid  = 1'b0;
        res.tx_char   = '0;
        res.rx_take   = 1'b0;
        res.last      = 1'b1;
        case (item.func)
            tms_pkg::FUNC_CTRL_WR:
            begin
                level_next = item.bus_word[2:0];
                sel_next   = item.bus_word[tms_pkg::CW_SEL_LSB +: tms_pkg::LINE_W];
                if (item.bus_word[tms_pkg::CW_STOP_BIT])
                begin
                    odone_next = 1'b0;
                end
                if (item.bus_word[tms_pkg::CW_REQ_BIT])
                begin
                    odone_next = 1'b1;
                end
            end
            tms_pkg::FUNC_STAT_RD:
            begin
                res.read_data = {19'd0, sel_reg, 6'd0, idone_reg, 1'b0, odone_reg, level_reg};
            end
            tms_pkg::FUNC_DATA_WR:
            begin
                odone_next   = 1'b0;
                res.tx_valid = 1'b1;
                res.tx_char  = cur_char;
                res.last     = end_of_chars;
            end
            tms_pkg::FUNC_DATA_RD:
            begin
                idone_next    = 1'b0;
                res.read_data = {{(tms_pkg::WORD_W-tms_pkg::CHAR_W){1'b0}}, item.rx_char};
                res.rx_take   = 1'b1;
            end
            tms_pkg::FUNC_SCAN:
            begin
                if (scan_hit.found)
                begin
                    sel_next = scan_hit.line;
                    ptr_next = scan_hit.line;
                    if (scan_hit.is_tx)
                    begin
                        odone_next = 1'b1;
                    end
                    else
                    begin
                        idone_next = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.sel_line   = sel_next;
        res.irq_active = odone_next | idone_next;
        res.irq_level  = level_next;
        idx_next       = res.last ? '0 : idx_reg + tms_pkg::IDX_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            sel_reg   <= '0;
            odone_reg <= 1'b0;
            idone_reg <= 1'b0;
            ptr_reg   <= '0;
            idx_reg   <= '0;
        end
        else if (fire)
        begin
            level_reg <= level_next;
            sel_reg   <= sel_next;
            odone_reg <= odone_next;
            idone_reg <= idone_next;
            ptr_reg   <= ptr_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ===== rtl/tms_checker.sv =====
// Port-level checker for the terminal multiplexer status and scan core, with its bind.
// Depends on tms_pkg and on the top level's port list.
module tms_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input tms_pkg::item_t   item,
    input logic             result_valid,
    input logic             result_stall,
    input tms_pkg::result_t result
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(item))
        else $error("Stalled input transaction changed.");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("Stalled result transaction changed.");

    a_tx_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.tx_valid |-> result.read_data == '0 && !result.rx_take)
        else $error("Character transaction carries read data.");

    a_multi: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> result.tx_valid)
        else $error("Only a data write may give several result transactions.");

    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !result.last
        |=> result_valid && result.tx_valid && $stable(result.sel_line)
            && $stable(result.irq_level))
        else $error("Character burst broke off or state changed within it.");

endmodule

bind terminal_mux_status_and_scan_core tms_checker u_tms_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
